/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked at every edge, reset included
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/bsci_pkg.sv */
// ----------------------------------------------------------------------------
// bsci_pkg
// Types, constants and helpers for the bitset cover intersect counter.
// ----------------------------------------------------------------------------
package bsci_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned CNT_W       = 7;
    localparam int unsigned SUM_W       = 17;
    localparam int unsigned NCLS_W      = 3;
    localparam int unsigned CLASS_INPUTS = 4;

    localparam logic [SUM_W-1:0]  SUM_LIMIT   = 17'd65536;
    localparam logic [NCLS_W-1:0] TWO_CLASSES = 3'd2;

    // Decoded class configuration
    typedef struct packed {
        logic                    two_mode;
        logic [CLASS_INPUTS-1:0] in_use;
    } cls_cfg_t;

    // Per-word counts handed from the count stage to the accumulator
    typedef struct packed {
        logic [DATA_W-1:0]                  word;
        logic [CNT_W-1:0]                   sup;
        logic [CLASS_INPUTS-1:0][CNT_W-1:0] cls_cnt;
        logic                               last;
    } count_t;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

    // Byte-wise popcount
    function automatic logic [CNT_W-1:0] pop64(input logic [DATA_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int b = 0; b < 8; b++) begin
            n = n + {3'b000, pop8(v[8*b +: 8])};
        end
        return n;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W+1-CNT_W){1'b0}}, b};
        return (s > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : s[SUM_W-1:0];
    endfunction

    // Clamp to 2..4 and to the build-time class limit
    function automatic cls_cfg_t cls_decode(input logic [NCLS_W-1:0] num,
                                            input int unsigned      max_cls);
        cls_cfg_t   c;
        logic [3:0] n;
        n = {1'b0, num};
        if (n < 4'd2) n = 4'd2;
        if (n > 4'd4) n = 4'd4;
        if (n > 4'(max_cls)) n = 4'(max_cls);
        c.two_mode = (n == 4'd2);
        for (int k = 0; k < CLASS_INPUTS; k++) begin
            c.in_use[k] = (4'(k) < n);
        end
        return c;
    endfunction

endpackage

/* rtl/bitset_cover_intersect_count.sv */
// ----------------------------------------------------------------------------
// bitset_cover_intersect_count
// Cover-word intersection with popcount and per-class support totals.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel carries one 64-bit cover word, the matching
//   attribute word, up to four class words, the polarity flag (s_tuser) and
//   the last-word mark (s_tlast). The block ANDs cover with the attribute (or
//   its complement) and returns on the m_ channel the new word, its popcount,
//   an empty flag (m_tuser) and saturating running totals, with m_tlast set on
//   the last word of a run. The running sums clear after that word.
//   num_classes is written on the cfg_ channel; the user writes it only while the block is idle, not enforced here.
// Pipeline and throughput:
//   One request per cycle while m_tready is not held low. A request passes
//   through the input register, the count register (AND and popcounts) and
//   the result register (saturating accumulate) before it is shown on m_.
// Reset:
//   Synchronous, active low. Pipeline empties, sums clear, num_classes is 2.
// Back-pressure:
//   While m_tready is low the result holds; the two earlier stages still fill,
//   so s_tready drops only once all three stages hold requests.
// ----------------------------------------------------------------------------
module bitset_cover_intersect_count #(
    parameter int unsigned WORD_BITS   = 64,
    parameter int unsigned MAX_CLASSES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] cover_word, [127:64] attribute_word, [191:128] class_zero_word,
    // [255:192] class_one_word, [319:256] class_two_word,
    // [383:320] class_three_word
    input  logic [383:0] s_tdata,
    // [0] positive
    input  logic         s_tuser,
    // last_word
    input  logic         s_tlast,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] new_word, [70:64] word_support, [87:71] total_support,
    // [104:88] class_zero_total, [121:105] class_one_total,
    // [138:122] class_two_total, [155:139] class_three_total, [159:156] zero
    output logic [159:0] m_tdata,
    // [0] word_empty
    output logic         m_tuser,
    // totals_valid
    output logic         m_tlast,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data     // num_classes
);

    localparam int unsigned DW = bsci_pkg::DATA_W;
    localparam int unsigned SW = bsci_pkg::SUM_W;

    logic [bsci_pkg::NCLS_W-1:0] num_classes_reg;
    bsci_pkg::cls_cfg_t          cls_cfg;

    logic [bsci_pkg::CLASS_INPUTS-1:0][DW-1:0] class_words;

    logic             cnt_valid;
    logic             cnt_ready;
    bsci_pkg::count_t cnt;

    logic [DW-1:0]                                  new_word;
    logic                                           word_empty;
    logic [bsci_pkg::CNT_W-1:0]                     word_support;
    logic [SW-1:0]                                  total_support;
    logic [bsci_pkg::CLASS_INPUTS-1:0][SW-1:0]      class_totals;
    logic                                           totals_valid;

    // Configuration: always ready, one register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_classes_reg <= bsci_pkg::TWO_CLASSES;
        end else if (cfg_valid && cfg_ready) begin
            num_classes_reg <= cfg_data;
        end
    end

    // Out-of-range counts clamp to 2..4 and MAX_CLASSES
    assign cls_cfg = bsci_pkg::cls_decode(num_classes_reg, MAX_CLASSES);

    // Unpack class words from the stream payload
    always_comb begin
        for (int k = 0; k < bsci_pkg::CLASS_INPUTS; k++) begin
            class_words[k] = s_tdata[2*DW + k*DW +: DW];
        end
    end

    bsci_count #(
        .WORD_BITS (WORD_BITS)
    ) u_count (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .cover_word     (s_tdata[DW-1:0]),
        .attribute_word (s_tdata[2*DW-1:DW]),
        .positive       (s_tuser),
        .class_words    (class_words),
        .last_word      (s_tlast),
        .cls_cfg        (cls_cfg),
        .cnt_valid      (cnt_valid),
        .cnt_ready      (cnt_ready),
        .cnt            (cnt)
    );

    bsci_accum u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cnt_valid     (cnt_valid),
        .cnt_ready     (cnt_ready),
        .cnt           (cnt),
        .cls_cfg       (cls_cfg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .new_word      (new_word),
        .word_empty    (word_empty),
        .word_support  (word_support),
        .total_support (total_support),
        .class_totals  (class_totals),
        .totals_valid  (totals_valid)
    );

    // Pack the result, lowest field first, zero fill to a whole byte
    assign m_tdata = {4'b0000,
                      class_totals[3], class_totals[2],
                      class_totals[1], class_totals[0],
                      total_support, word_support, new_word};
    assign m_tuser = word_empty;
    assign m_tlast = totals_valid;

endmodule

/* rtl/bsci_count.sv */
// ----------------------------------------------------------------------------
// bsci_count
// Input register, then AND with attribute and popcounts into a count register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsci_count #(
    parameter int unsigned WORD_BITS = 64
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   in_valid,
    output logic                                                   in_ready,
    input  logic [bsci_pkg::DATA_W-1:0]                            cover_word,
    input  logic [bsci_pkg::DATA_W-1:0]                            attribute_word,
    input  logic                                                   positive,
    input  logic [bsci_pkg::CLASS_INPUTS-1:0][bsci_pkg::DATA_W-1:0] class_words,
    input  logic                                                   last_word,
    input  bsci_pkg::cls_cfg_t                                     cls_cfg,
    output logic                                                   cnt_valid,
    input  logic                                                   cnt_ready,
    output bsci_pkg::count_t                                       cnt
);

    localparam logic [bsci_pkg::DATA_W-1:0] WORD_MASK =
        (WORD_BITS >= 64) ? {bsci_pkg::DATA_W{1'b1}}
                          : ((64'd1 << WORD_BITS) - 64'd1);

    // stage 1: captured request
    logic                                                     s1_valid_reg;
    logic [bsci_pkg::DATA_W-1:0]                              s1_cover_reg;
    logic [bsci_pkg::DATA_W-1:0]                              s1_attr_reg;
    logic                                                     s1_pos_reg;
    logic [bsci_pkg::CLASS_INPUTS-1:0][bsci_pkg::DATA_W-1:0]  s1_cls_reg;
    logic                                                     s1_last_reg;

    // stage 2: counts
    logic             s2_valid_reg;
    bsci_pkg::count_t s2_reg;
    bsci_pkg::count_t s2_next;

    logic s1_ready;
    logic s2_ready;
    logic [bsci_pkg::DATA_W-1:0] word;

    assign s2_ready = !s2_valid_reg || cnt_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        word = s1_cover_reg & (s1_pos_reg ? s1_attr_reg : ~s1_attr_reg) & WORD_MASK;
        s2_next.word = word;
        s2_next.sup  = bsci_pkg::pop64(word);
        s2_next.last = s1_last_reg;
        for (int k = 0; k < bsci_pkg::CLASS_INPUTS; k++) begin
            s2_next.cls_cnt[k] = bsci_pkg::pop64(word & s1_cls_reg[k]);
        end
        // two classes: class one is the rest of the word's support
        if (cls_cfg.two_mode) begin
            s2_next.cls_cnt[1] = s2_next.sup - s2_next.cls_cnt[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && s1_ready) begin
            s1_cover_reg <= cover_word;
            s1_attr_reg  <= attribute_word;
            s1_pos_reg   <= positive;
            s1_cls_reg   <= class_words;
            s1_last_reg  <= last_word;
        end
        if (s1_valid_reg && s2_ready) begin
            s2_reg <= s2_next;
        end
    end

    assign cnt_valid = s2_valid_reg;
    assign cnt       = s2_reg;

    `ASSERT_CLKD(a_cls0_within_word, s2_valid_reg |-> (s2_reg.cls_cnt[0] <= s2_reg.sup),
        "class zero count exceeds word support")

endmodule

/* rtl/bsci_accum.sv */
// ----------------------------------------------------------------------------
// bsci_accum
// Saturating running sums and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsci_accum (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   cnt_valid,
    output logic                                                   cnt_ready,
    input  bsci_pkg::count_t                                       cnt,
    input  bsci_pkg::cls_cfg_t                                     cls_cfg,
    output logic                                                   out_valid,
    input  logic                                                   out_ready,
    output logic [bsci_pkg::DATA_W-1:0]                            new_word,
    output logic                                                   word_empty,
    output logic [bsci_pkg::CNT_W-1:0]                             word_support,
    output logic [bsci_pkg::SUM_W-1:0]                             total_support,
    output logic [bsci_pkg::CLASS_INPUTS-1:0][bsci_pkg::SUM_W-1:0] class_totals,
    output logic                                                   totals_valid
);

    logic [bsci_pkg::SUM_W-1:0]                              sup_sum_reg;
    logic [bsci_pkg::SUM_W-1:0]                              sup_sum_next;
    logic [bsci_pkg::CLASS_INPUTS-1:0][bsci_pkg::SUM_W-1:0]  cls_sum_reg;
    logic [bsci_pkg::CLASS_INPUTS-1:0][bsci_pkg::SUM_W-1:0]  cls_sum_next;
    logic [bsci_pkg::CLASS_INPUTS-1:0][bsci_pkg::SUM_W-1:0]  cls_out;

    logic                                                    out_valid_reg;
    logic [bsci_pkg::DATA_W-1:0]                             word_reg;
    logic                                                    empty_reg;
    logic [bsci_pkg::CNT_W-1:0]                              sup_reg;
    logic [bsci_pkg::SUM_W-1:0]                              tot_reg;
    logic [bsci_pkg::CLASS_INPUTS-1:0][bsci_pkg::SUM_W-1:0]  cls_tot_reg;
    logic                                                    last_reg;

    logic load;

    assign cnt_ready = !out_valid_reg || out_ready;
    assign load      = cnt_valid && cnt_ready;

    always_comb begin
        sup_sum_next = bsci_pkg::sat_add(sup_sum_reg, cnt.sup);
        for (int k = 0; k < bsci_pkg::CLASS_INPUTS; k++) begin
            cls_sum_next[k] = cls_cfg.in_use[k]
                            ? bsci_pkg::sat_add(cls_sum_reg[k], cnt.cls_cnt[k])
                            : cls_sum_reg[k];
            cls_out[k]      = cls_cfg.in_use[k] ? cls_sum_next[k] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sup_sum_reg   <= '0;
            cls_sum_reg   <= '0;
        end else begin
            if (cnt_ready) begin
                out_valid_reg <= cnt_valid;
            end
            if (load) begin
                // sums restart after the last word of a run
                sup_sum_reg <= cnt.last ? '0 : sup_sum_next;
                cls_sum_reg <= cnt.last ? '0 : cls_sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg    <= cnt.word;
            empty_reg   <= (cnt.word == '0);
            sup_reg     <= cnt.sup;
            tot_reg     <= sup_sum_next;
            cls_tot_reg <= cls_out;
            last_reg    <= cnt.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_word      = word_reg;
    assign word_empty    = empty_reg;
    assign word_support  = sup_reg;
    assign total_support = tot_reg;
    assign class_totals  = cls_tot_reg;
    assign totals_valid  = last_reg;

    `ASSERT_CLK(a_reset_idle, !aresetn |=> !out_valid_reg,
        "result valid straight after reset")
    `ASSERT_CLKD(a_clear_after_last,
        (load && cnt.last) |=> (sup_sum_reg == '0 && cls_sum_reg == '0),
        "sums not cleared after last word")
    `ASSERT_CLKD(a_sum_saturates, sup_sum_reg <= bsci_pkg::SUM_LIMIT,
        "support sum beyond limit")
    `ASSERT_CLKD(a_cls0_le_support, cls_sum_reg[0] <= sup_sum_reg,
        "class zero sum exceeds support sum")

endmodule
